FILE: hw/rtl/frm_pkg.sv
// Shared constants, codes and types for the fragment reassembly ring manager.
package frm_pkg;

   localparam int unsigned RING_BYTES  = 262144;
   localparam int unsigned ADDR_W      = 18;
   localparam int unsigned SPACE_W     = ADDR_W + 1;
   localparam int unsigned QUEUE_DEPTH = 16;
   localparam int unsigned QIDX_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned LEN_W       = 16;
   localparam int unsigned RECV_W      = LEN_W + 1;
   localparam int unsigned DROP_W      = 32;

   localparam logic [LEN_W-1:0] MAX_FRAME_RESET = LEN_W'(24 * 1024);

   // opcodes
   localparam logic [1:0] OP_PUSH    = 2'd0;
   localparam logic [1:0] OP_FETCH   = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_ARG   = 3'd1;
   localparam logic [2:0] ST_TOO_LARGE = 3'd2;
   localparam logic [2:0] ST_NO_ROOM   = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;

   typedef enum logic [2:0] {
      FSM_IDLE  = 3'b001,
      FSM_EXEC  = 3'b010,
      FSM_MEMRD = 3'b100
   } fsm_type;

   typedef struct packed {
      logic [ADDR_W-1:0] start;
      logic [LEN_W-1:0]  len;
   } desc_type;

   localparam int unsigned DESC_W = $bits(desc_type);

   // first member is the highest bits: status sits at bit 0
   typedef struct packed {
      logic [DROP_W-1:0] dropped_count;
      logic [LEN_W-1:0]  head_len;
      logic [ADDR_W-1:0] head_start;
      logic              frame_complete;
      logic [ADDR_W-1:0] write_addr;
      logic [2:0]        status;
   } rsp_type;

   localparam int unsigned RSP_W = $bits(rsp_type);

endpackage

FILE: hw/rtl/frm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module frm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/fragment_reassembly_ring_manager_unit.sv
// Top level of the fragment reassembly ring manager: pointers, frame queue and result stage.
//
// One word in, one word out. A push places a fragment of a frame in the byte ring
// (the DMA uses the returned write_addr), a fetch reports the oldest completed frame,
// a release retires it and moves the ring read pointer. Each item is taken in, then
// executed; pushes, unknown opcodes and empty-queue operations end there, while fetch
// and release on a non-empty queue add a read state, as the 16-entry descriptor memory
// has registered read data. The next word is accepted while a result still waits in
// the output register. The user must write max_frame_len through the csr channel only while
// the block is idle; the block does not enforce this. It resets to 24576. The descriptor
// memory needs no clearing after reset: only entries already written are ever read.
module fragment_reassembly_ring_manager_unit (
   input  logic        clock,
   input  logic        reset,
   // csr_data: max_frame_len[15:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data,
   // req_tdata: frag_offset[15:0], frag_len[31:16], frame_total[47:32]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,
   // req_tuser: opcode[1:0]
   input  logic [1:0]  req_tuser,
   // rsp_tdata: status[2:0], write_addr[20:3], frame_complete[21], head_start[39:22],
   //            head_len[55:40], dropped_count[87:56]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata
);

   localparam logic [frm_pkg::SPACE_W-1:0] RingSize = frm_pkg::SPACE_W'(frm_pkg::RING_BYTES);

   frm_pkg::fsm_type state_ff, state_in;

   logic [1:0]                    op_ff;
   logic [frm_pkg::LEN_W-1:0]     off_ff, len_ff, tot_ff;
   logic [frm_pkg::LEN_W-1:0]     max_len_ff;
   logic [frm_pkg::ADDR_W-1:0]    wp_ff, wp_in, rp_ff, rp_in;
   logic [frm_pkg::QIDX_W-1:0]    q_head_ff, q_head_in, q_tail_ff, q_tail_in;
   logic [frm_pkg::QCNT_W-1:0]    q_count_ff, q_count_in;
   logic [frm_pkg::LEN_W-1:0]     cur_total_ff, cur_total_in;
   logic [frm_pkg::ADDR_W-1:0]    cur_start_ff, cur_start_in;
   logic [frm_pkg::RECV_W-1:0]    cur_recv_ff, cur_recv_in;
   logic [frm_pkg::DROP_W-1:0]    drop_ff, drop_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   frm_pkg::rsp_type              rsp_ff, rsp_in;

   logic                          wr_en;
   frm_pkg::desc_type             wr_desc, rd_desc;
   logic [frm_pkg::DESC_W-1:0]    rd_data;
   logic [frm_pkg::QIDX_W-1:0]    rd_addr, head_next, tail_next;
   logic                          slot_free, q_full;

   // push datapath
   logic                          is_start, bad_len, placed;
   logic [frm_pkg::SPACE_W-1:0]   used, avail, need, wp_sum;
   logic [frm_pkg::RECV_W-1:0]    recv_base, frag_end;
   logic [frm_pkg::ADDR_W-1:0]    start_base;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == frm_pkg::FSM_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign q_full     = (q_count_ff >= frm_pkg::QCNT_W'(frm_pkg::QUEUE_DEPTH));

   assign head_next = (q_head_ff == frm_pkg::QIDX_W'(frm_pkg::QUEUE_DEPTH - 1)) ?
                      '0 : q_head_ff + 1'b1;
   assign tail_next = (q_tail_ff == frm_pkg::QIDX_W'(frm_pkg::QUEUE_DEPTH - 1)) ?
                      '0 : q_tail_ff + 1'b1;
   // held steady through EXEC and MEMRD so the registered read stays valid
   assign rd_addr   = (op_ff == frm_pkg::OP_RELEASE) ? head_next : q_head_ff;
   assign rd_desc   = rd_data;

   assign is_start   = (off_ff == '0);
   assign bad_len    = (len_ff == '0) || (tot_ff == '0);
   assign start_base = is_start ? wp_ff : cur_start_ff;
   assign recv_base  = is_start ? '0 : cur_recv_ff;
   assign used       = (wp_ff >= rp_ff) ?
                       {1'b0, wp_ff} - {1'b0, rp_ff} :
                       {1'b0, wp_ff} + RingSize - {1'b0, rp_ff};
   assign avail      = RingSize - used - 1'b1;
   assign need       = is_start ? frm_pkg::SPACE_W'(tot_ff) : frm_pkg::SPACE_W'(len_ff);
   assign wp_sum     = {1'b0, wp_ff} + frm_pkg::SPACE_W'(len_ff);
   assign frag_end   = frm_pkg::RECV_W'(off_ff) + frm_pkg::RECV_W'(len_ff);
   assign placed     = (avail >= need);

   assign wr_desc.start = start_base;
   assign wr_desc.len   = tot_ff;

   always_comb begin
      frm_pkg::rsp_type r;
      logic             commit;
      r            = '0;
      commit       = 1'b0;
      state_in     = state_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      q_head_in    = q_head_ff;
      q_tail_in    = q_tail_ff;
      q_count_in   = q_count_ff;
      cur_total_in = cur_total_ff;
      cur_start_in = cur_start_ff;
      cur_recv_in  = cur_recv_ff;
      drop_in      = drop_ff;
      wr_en        = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         frm_pkg::FSM_IDLE: begin
            if (req_tvalid) begin
               state_in = frm_pkg::FSM_EXEC;
            end
         end
         frm_pkg::FSM_EXEC: begin
            if (op_ff == frm_pkg::OP_PUSH) begin
               commit = slot_free;
               r.status = frm_pkg::ST_OK;
               if (bad_len) begin
                  r.status = frm_pkg::ST_BAD_ARG;
               end else if (is_start && (tot_ff > max_len_ff)) begin
                  r.status = frm_pkg::ST_TOO_LARGE;
               end else if (is_start && q_full) begin
                  r.status = frm_pkg::ST_NO_ROOM;
                  drop_in  = drop_ff + 1'b1;
               end else if (!is_start &&
                            ((cur_total_ff != tot_ff) ||
                             (cur_recv_ff != frm_pkg::RECV_W'(off_ff)))) begin
                  r.status     = frm_pkg::ST_BAD_ARG;
                  drop_in      = drop_ff + 1'b1;
                  cur_total_in = '0;
                  cur_recv_in  = '0;
               end else begin
                  cur_start_in = start_base;
                  if (!placed) begin
                     r.status     = frm_pkg::ST_NO_ROOM;
                     drop_in      = drop_ff + 1'b1;
                     cur_total_in = '0;
                     cur_recv_in  = '0;
                  end else begin
                     r.write_addr = wp_ff;
                     wp_in = (wp_sum >= RingSize) ? frm_pkg::ADDR_W'(wp_sum - RingSize) :
                                                    frm_pkg::ADDR_W'(wp_sum);
                     cur_total_in = tot_ff;
                     cur_recv_in  = recv_base + frm_pkg::RECV_W'(len_ff);
                     if (frag_end == frm_pkg::RECV_W'(tot_ff)) begin
                        cur_total_in = '0;
                        cur_recv_in  = '0;
                        if (q_full) begin
                           r.status = frm_pkg::ST_NO_ROOM;
                           drop_in  = drop_ff + 1'b1;
                        end else begin
                           wr_en            = commit;
                           q_tail_in        = tail_next;
                           q_count_in       = q_count_ff + 1'b1;
                           r.frame_complete = 1'b1;
                        end
                     end else if (frag_end > frm_pkg::RECV_W'(tot_ff)) begin
                        // overrun: bytes already placed, frame abandoned
                        r.status     = frm_pkg::ST_BAD_ARG;
                        drop_in      = drop_ff + 1'b1;
                        cur_total_in = '0;
                        cur_recv_in  = '0;
                     end
                  end
               end
            end else if ((op_ff == frm_pkg::OP_FETCH) || (op_ff == frm_pkg::OP_RELEASE)) begin
               if (q_count_ff == '0) begin
                  commit   = slot_free;
                  r.status = frm_pkg::ST_EMPTY;
               end else begin
                  state_in = frm_pkg::FSM_MEMRD;
               end
            end else begin
               commit   = slot_free;
               r.status = frm_pkg::ST_BAD_ARG;
            end
         end
         frm_pkg::FSM_MEMRD: begin
            commit = slot_free;
            if (op_ff == frm_pkg::OP_FETCH) begin
               r.head_start = rd_desc.start;
               r.head_len   = rd_desc.len;
               r.status     = (rd_desc.len > max_len_ff) ? frm_pkg::ST_TOO_LARGE :
                                                           frm_pkg::ST_OK;
            end else begin
               r.status   = frm_pkg::ST_OK;
               q_head_in  = head_next;
               q_count_in = q_count_ff - 1'b1;
               rp_in      = (q_count_ff == frm_pkg::QCNT_W'(1)) ? wp_ff : rd_desc.start;
            end
         end
         default: begin
            state_in = frm_pkg::FSM_IDLE;
         end
      endcase

      if (commit) begin
         r.dropped_count = drop_in;
         rsp_in          = r;
         rsp_valid_in    = 1'b1;
         state_in        = frm_pkg::FSM_IDLE;
      end else if (state_ff != frm_pkg::FSM_IDLE) begin
         // no result committed (output register full, or moving on to MEMRD): hold pointer, queue, frame and drop state
         wp_in        = wp_ff;
         rp_in        = rp_ff;
         q_head_in    = q_head_ff;
         q_tail_in    = q_tail_ff;
         q_count_in   = q_count_ff;
         cur_total_in = cur_total_ff;
         cur_start_in = cur_start_ff;
         cur_recv_in  = cur_recv_ff;
         drop_in      = drop_ff;
      end
   end

   frm_ram #(
      .WIDTH(frm_pkg::DESC_W),
      .DEPTH(frm_pkg::QUEUE_DEPTH)
   ) u_desc_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(q_tail_ff),
      .wr_data(wr_desc),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= frm_pkg::FSM_IDLE;
         max_len_ff   <= frm_pkg::MAX_FRAME_RESET;
         wp_ff        <= '0;
         rp_ff        <= '0;
         q_head_ff    <= '0;
         q_tail_ff    <= '0;
         q_count_ff   <= '0;
         cur_total_ff <= '0;
         cur_start_ff <= '0;
         cur_recv_ff  <= '0;
         drop_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         q_head_ff    <= q_head_in;
         q_tail_ff    <= q_tail_in;
         q_count_ff   <= q_count_in;
         cur_total_ff <= cur_total_in;
         cur_start_ff <= cur_start_in;
         cur_recv_ff  <= cur_recv_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            max_len_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (req_tvalid && req_tready) begin
         op_ff  <= req_tuser;
         off_ff <= req_tdata[15:0];
         len_ff <= req_tdata[31:16];
         tot_ff <= req_tdata[47:32];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      q_count_ff <= frm_pkg::QCNT_W'(frm_pkg::QUEUE_DEPTH))
      else $error("frame queue count above depth");

   a_wp_in_ring: assert property (@(posedge clock) disable iff (reset)
      frm_pkg::SPACE_W'(wp_ff) < RingSize)
      else $error("write pointer outside ring");

   a_complete_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.frame_complete |-> rsp_ff.status == frm_pkg::ST_OK)
      else $error("frame completion reported with error status");

   a_count_moves: assert property (@(posedge clock) disable iff (reset)
      (q_count_ff != $past(q_count_ff)) && !$past(reset) |->
      $past(state_ff) != frm_pkg::FSM_IDLE && $past(slot_free))
      else $error("queue count changed without a committed item");

endmodule

FILE: tb/fragment_reassembly_ring_manager_unit_test.sv
// Self-checking testbench for the fragment reassembly ring manager: random and directed words.
module fragment_reassembly_ring_manager_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int unsigned QUIET_LIMIT = 2000;
   localparam int unsigned SHOW_LIMIT  = 10;

   // Tracks the ring pointers and frame queue, and queues the result each request word
   // should give.
   class frame_ring_scoreboard;
      logic [frm_pkg::LEN_W-1:0]  max_len;
      logic [frm_pkg::ADDR_W-1:0] wr_ptr;
      logic [frm_pkg::ADDR_W-1:0] rd_ptr;
      logic [frm_pkg::ADDR_W-1:0] q_start [frm_pkg::QUEUE_DEPTH];
      logic [frm_pkg::LEN_W-1:0]  q_len [frm_pkg::QUEUE_DEPTH];
      logic [frm_pkg::QIDX_W-1:0] q_head;
      logic [frm_pkg::QIDX_W-1:0] q_tail;
      logic [frm_pkg::QCNT_W-1:0] q_count;
      logic [frm_pkg::LEN_W-1:0]  cur_total;
      logic [frm_pkg::ADDR_W-1:0] cur_start;
      logic [frm_pkg::RECV_W-1:0] cur_recv;
      logic [frm_pkg::DROP_W-1:0] drops;
      frm_pkg::rsp_type           expected_q[$];
      int unsigned                failures;
      int unsigned                results_seen;
      int unsigned                frames_done;
      int unsigned                status_seen [8];

      function new();
         max_len = frm_pkg::MAX_FRAME_RESET;
         wr_ptr = '0;
         rd_ptr = '0;
         q_head = '0;
         q_tail = '0;
         q_count = '0;
         cur_total = '0;
         cur_start = '0;
         cur_recv = '0;
         drops = '0;
         failures = 0;
         results_seen = 0;
         frames_done = 0;
         foreach (q_start[i]) begin
            q_start[i] = '0;
            q_len[i] = '0;
         end
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function void abandon_frame();
         drops = drops + 1'b1;
         cur_total = '0;
         cur_recv = '0;
      endfunction

      function void note_request(logic [1:0] op, logic [15:0] off, logic [15:0] len,
                                 logic [15:0] total);
         frm_pkg::rsp_type           e;
         logic [frm_pkg::ADDR_W-1:0] used;
         logic [frm_pkg::RECV_W-1:0] end_pos;
         int unsigned                avail;
         int unsigned                need;
         e = '0;
         e.status = frm_pkg::ST_BAD_ARG;
         case (op)
            frm_pkg::OP_PUSH: begin
               if (len == 0 || total == 0) begin
                  e.status = frm_pkg::ST_BAD_ARG;
               end else if (off == 0 && total > max_len) begin
                  e.status = frm_pkg::ST_TOO_LARGE;
               end else if (off == 0 && q_count >= frm_pkg::QUEUE_DEPTH) begin
                  drops = drops + 1'b1;
                  e.status = frm_pkg::ST_NO_ROOM;
               end else if (off != 0 && (cur_total != total || {1'b0, off} != cur_recv)) begin
                  abandon_frame();
                  e.status = frm_pkg::ST_BAD_ARG;
               end else begin
                  if (off == 0) begin
                     cur_total = total;
                     cur_start = wr_ptr;
                     cur_recv = '0;
                  end
                  used = wr_ptr - rd_ptr;
                  avail = frm_pkg::RING_BYTES - 1 - used;
                  // a start fragment reserves the whole frame
                  need = (off == 0) ? total : len;
                  if (avail < need) begin
                     abandon_frame();
                     e.status = frm_pkg::ST_NO_ROOM;
                  end else begin
                     e.status = frm_pkg::ST_OK;
                     e.write_addr = wr_ptr;
                     wr_ptr = wr_ptr + len;
                     cur_recv = cur_recv + len;
                     end_pos = {1'b0, off} + {1'b0, len};
                     if (end_pos == total) begin
                        if (q_count >= frm_pkg::QUEUE_DEPTH) begin
                           abandon_frame();
                           e.status = frm_pkg::ST_NO_ROOM;
                        end else begin
                           q_start[q_tail] = cur_start;
                           q_len[q_tail] = cur_total;
                           q_tail = frm_pkg::QIDX_W'((q_tail + 1) % frm_pkg::QUEUE_DEPTH);
                           q_count = q_count + 1'b1;
                           cur_total = '0;
                           cur_recv = '0;
                           e.frame_complete = 1'b1;
                           frames_done++;
                        end
                     end else if (end_pos > total) begin
                        // bytes already placed, frame is lost anyway
                        abandon_frame();
                        e.status = frm_pkg::ST_BAD_ARG;
                     end
                  end
               end
            end
            frm_pkg::OP_FETCH: begin
               if (q_count == 0) begin
                  e.status = frm_pkg::ST_EMPTY;
               end else begin
                  e.head_start = q_start[q_head];
                  e.head_len = q_len[q_head];
                  e.status = (q_len[q_head] > max_len) ? frm_pkg::ST_TOO_LARGE :
                                                         frm_pkg::ST_OK;
               end
            end
            frm_pkg::OP_RELEASE: begin
               if (q_count == 0) begin
                  e.status = frm_pkg::ST_EMPTY;
               end else begin
                  q_head = frm_pkg::QIDX_W'((q_head + 1) % frm_pkg::QUEUE_DEPTH);
                  q_count = q_count - 1'b1;
                  rd_ptr = (q_count != 0) ? q_start[q_head] : wr_ptr;
                  e.status = frm_pkg::ST_OK;
               end
            end
            default: e.status = frm_pkg::ST_BAD_ARG;
         endcase
         e.dropped_count = drops;
         status_seen[e.status]++;
         expected_q.push_back(e);
      endfunction

      function string show(frm_pkg::rsp_type r);
         return $sformatf("status %0d waddr %h done %0d head %h len %0d drops %0d",
                          r.status, r.write_addr, r.frame_complete, r.head_start,
                          r.head_len, r.dropped_count);
      endfunction

      function void note_failure(string msg);
         failures++;
         if (failures <= SHOW_LIMIT) $display("MISMATCH: %s", msg);
      endfunction

      function void check_response(frm_pkg::rsp_type got);
         frm_pkg::rsp_type want;
         if (expected_q.size() == 0) begin
            note_failure($sformatf("result word with nothing expected: %s", show(got)));
            return;
         end
         want = expected_q.pop_front();
         results_seen++;
         if (got.status !== want.status || got.write_addr !== want.write_addr ||
             got.frame_complete !== want.frame_complete ||
             got.head_start !== want.head_start || got.head_len !== want.head_len ||
             got.dropped_count !== want.dropped_count)
            note_failure($sformatf("result %0d expected %s, got %s", results_seen,
                                   show(want), show(got)));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;

   frame_ring_scoreboard sb;
   int unsigned          words_sent = 0;
   int unsigned          burst_left = 0;
   int unsigned          settings_used = 1;

   // receiver stall pattern state
   int unsigned rx_mode = 0;
   int unsigned rx_left = 0;
   logic [7:0]  rx_mask = 8'hFF;
   logic [2:0]  rx_phase = '0;

   fragment_reassembly_ring_manager_unit dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode <= $urandom_range(0, 3);
         rx_mask <= 8'($urandom) | 8'h01;
         rx_left <= $urandom_range(20, 120);
      end else begin
         rx_left <= rx_left - 1;
      end
      rx_phase <= rx_phase + 1'b1;
      case (rx_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= rx_mask[rx_phase];
         2: rsp_tready <= ($urandom_range(0, 1) == 1);
         default: rsp_tready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(frm_pkg::rsp_type'(rsp_tdata));
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic send_word(input logic [1:0] op, input logic [15:0] off,
                            input logic [15:0] len, input logic [15:0] total);
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {total, len, off};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, off, len, total);
      words_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         // now and then a long back-to-back stretch
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(0, 12);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_max_len(input logic [15:0] value);
      wait_for_results();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.max_len = value;
      settings_used++;
   endtask

   function automatic logic [15:0] pick_total(bit big);
      int unsigned top;
      int unsigned r;
      top = sb.max_len;
      r = $urandom_range(0, 9);
      if (r == 0) return sb.max_len;
      if (r == 1) return 16'($urandom_range(top, 65535));
      if (big || r == 2) return 16'($urandom_range(1, top));
      return 16'($urandom_range(1, (top < 400) ? top : 400));
   endfunction

   task automatic random_phase(input int unsigned count, input int unsigned release_pct,
                               input bit big);
      int unsigned stop_at;
      int unsigned r;
      int unsigned total;
      int unsigned nfrag;
      int unsigned flaw;
      int unsigned off;
      int unsigned len;
      logic [15:0] w_off;
      logic [15:0] w_len;
      logic [15:0] w_total;
      stop_at = words_sent + count;
      while (words_sent < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            // a well-formed frame in up to four fragments, sometimes with one flaw
            total = pick_total(big);
            nfrag = $urandom_range(1, 4);
            if (nfrag > total) nfrag = total;
            flaw = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 0;
            off = 0;
            for (int i = 0; i < nfrag; i++) begin
               len = (i == nfrag - 1) ? total - off
                                      : $urandom_range(1, total - off - (nfrag - 1 - i));
               w_off = 16'(off);
               w_len = 16'(len);
               w_total = 16'(total);
               if (i == nfrag - 1) begin
                  case (flaw)
                     1: w_off = 16'(off + 1);
                     2: w_total = 16'(total + 1);
                     3: w_len = 16'(len + 5);
                     default: ;
                  endcase
               end
               if (!(i == nfrag - 1 && flaw == 4)) begin
                  send_word(frm_pkg::OP_PUSH, w_off, w_len, w_total);
               end
               off += len;
            end
         end else if (r < 65) begin
            send_word(frm_pkg::OP_FETCH, 16'($urandom), 16'($urandom), 16'($urandom));
         end else if (r < 65 + release_pct) begin
            send_word(frm_pkg::OP_RELEASE, 16'($urandom), 16'($urandom), 16'($urandom));
         end else begin
            send_word(2'($urandom),
                      ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom),
                      ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom),
                      ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom));
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_word(frm_pkg::OP_FETCH, 16'd0, 16'd0, 16'd0);           // empty queue
      send_word(frm_pkg::OP_RELEASE, 16'd0, 16'd0, 16'd0);
      send_word(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_word(frm_pkg::OP_PUSH, 16'd0, 16'd0, 16'd16);           // zero length
      send_word(frm_pkg::OP_PUSH, 16'd0, 16'd16, 16'd0);           // zero total
      send_word(frm_pkg::OP_PUSH, 16'd0, 16'd16, 16'hFFFF);        // over the size limit
      send_word(frm_pkg::OP_PUSH, 16'd100, 16'd10, 16'd200);       // continuation, no frame open
      send_word(frm_pkg::OP_PUSH, 16'd0, frm_pkg::MAX_FRAME_RESET, frm_pkg::MAX_FRAME_RESET);
      send_word(frm_pkg::OP_PUSH, 16'd0, 16'd100, 16'd300);
      send_word(frm_pkg::OP_PUSH, 16'd100, 16'd200, 16'd300);
      send_word(frm_pkg::OP_PUSH, 16'd0, 16'd10, 16'd50);
      send_word(frm_pkg::OP_PUSH, 16'd20, 16'd10, 16'd50);         // offset gap
      send_word(frm_pkg::OP_PUSH, 16'd0, 16'd10, 16'd50);
      send_word(frm_pkg::OP_PUSH, 16'd10, 16'd10, 16'd60);         // total disagrees
      send_word(frm_pkg::OP_PUSH, 16'd0, 16'd10, 16'd50);
      send_word(frm_pkg::OP_PUSH, 16'd10, 16'd60, 16'd50);         // overrun
      send_word(frm_pkg::OP_PUSH, 16'd0, 16'd1, 16'd1);
      write_max_len(16'd100);
      send_word(frm_pkg::OP_FETCH, 16'd0, 16'd0, 16'd0);           // head now larger than limit
      send_word(frm_pkg::OP_RELEASE, 16'd0, 16'd0, 16'd0);
      send_word(frm_pkg::OP_FETCH, 16'd0, 16'd0, 16'd0);
      send_word(frm_pkg::OP_RELEASE, 16'd0, 16'd0, 16'd0);
      send_word(frm_pkg::OP_RELEASE, 16'd0, 16'd0, 16'd0);         // queue empties
      send_word(frm_pkg::OP_RELEASE, 16'd0, 16'd0, 16'd0);
      write_max_len(frm_pkg::MAX_FRAME_RESET);

      random_phase(450, 15, 1'b0);
      write_max_len(16'hFFFF);
      random_phase(250, 4, 1'b1);                          // big frames fill the ring
      write_max_len(16'd1);
      random_phase(150, 12, 1'b0);
      write_max_len(16'($urandom_range(2, 65534)));
      random_phase(250, 3, 1'b0);                          // few releases, queue runs full
      write_max_len(frm_pkg::MAX_FRAME_RESET);
      random_phase(300, 15, 1'b0);

      wait_for_results();
      repeat (8) @(posedge clock);

      $display("covered %0d request words over %0d limit settings: %0d frames, %0d drops",
               words_sent, settings_used, sb.frames_done, sb.drops);
      $display("status mix: ok %0d, bad arg %0d, too large %0d, no room %0d, empty %0d",
               sb.status_seen[frm_pkg::ST_OK], sb.status_seen[frm_pkg::ST_BAD_ARG],
               sb.status_seen[frm_pkg::ST_TOO_LARGE], sb.status_seen[frm_pkg::ST_NO_ROOM],
               sb.status_seen[frm_pkg::ST_EMPTY]);
      if (sb.failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", sb.failures);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
